// ===== sv/bpa_pkg.sv =====
// shared types and constants of the bitmap page allocator
`default_nettype none

package bpa_pkg;

    // default sizes
    localparam int MAX_POOL_PAGES_DEF = 4096;
    localparam int WORD_BITS_DEF      = 64;

    // field widths
    localparam int OP_W      = 2;
    localparam int CNT_W     = 13;
    localparam int PAGE_W    = 12;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 13;

    // saturation limit of the used-page count
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // register reset values
    localparam logic [CNT_W-1:0]  POOL_PAGES_RST = CNT_W'(4096);
    localparam logic [PAGE_W-1:0] BASE_OFFS_RST  = '0;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC         = 2'd0,
        OP_ALLOC_ALIGNED = 2'd1,
        OP_FREE          = 2'd2
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POOL_PAGES  = 1'b0,
        CFG_BASE_OFFSET = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [CNT_W-1:0]  page_count;
        logic [PAGE_W-1:0] first_page;
    } t_req;

    typedef struct packed {
        logic              success;
        logic [PAGE_W-1:0] start_page;
        logic [CNT_W-1:0]  pages_in_use;
    } t_rsp;

endpackage

`default_nettype wire

// ===== sv/bpa_stream_if.sv =====
// valid/ready channel carrying one word of type T
`default_nettype none

interface bpa_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/bpa_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
`default_nettype none

module bpa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

`default_nettype wire

// ===== sv/bitmap_page_allocator_top.sv =====
// bitmap page allocator: contiguous page runs out of a used-page bitmap in ram
// One request word in, one result word out; the block takes one request at a
// time and is not ready while it works. The used-page bitmap lives in a ram of
// ceil(MAX_POOL_PAGES / WORD_BITS) words with registered read; a valid flag
// per ram word (cleared by reset) makes a never-written word read as all
// free, so there is no clearing pass after reset. WORD_BITS must be a power
// of two: a page number splits into word and bit by a shift and a mask. All
// work goes through one sequencer around that single ram port. A request
// is accepted in S_IDLE; an allocation then reads and checks each bitmap word
// scanned for a free page (S_SCAN_RD, S_SCAN_CHK), checks each candidate's
// alignment (S_ALIGN), reads and checks each bitmap word of the run (S_RUN_RD,
// S_RUN_CHK) and reads and writes each bitmap word marked (S_RMW_RD,
// S_RMW_WR); a misaligned candidate restarts the scan at the next aligned
// page, and a run broken by a used page costs one scan for the next free page
// plus one more scan and check of that page. A free reads and writes each
// bitmap word cleared, and the result is posted in S_DONE. Results wait in an
// output register, so a new request is taken while the previous result is
// still unread; the block then holds in its last state until that result is
// read. Only whole bitmap words below the pool size are searched; pages of a
// trailing partial word are never handed out.
`default_nettype none

module bitmap_page_allocator_top #(
    parameter int MAX_POOL_PAGES = bpa_pkg::MAX_POOL_PAGES_DEF,
    parameter int WORD_BITS      = bpa_pkg::WORD_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // configuration write port
    input  wire logic                         i_cfg_we,
    input  wire logic [bpa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [bpa_pkg::CFG_W-1:0]     i_cfg_data,
    // request and result channels
    bpa_stream_if.sink                        i_req,
    bpa_stream_if.source                      o_rsp
);
    import bpa_pkg::*;

    // bitmap geometry
    localparam int NUM_WORDS = (MAX_POOL_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    // page positions: pool size plus the largest alignment step and count
    localparam int NW        = $clog2(MAX_POOL_PAGES + 2 ** (CNT_W + 1));
    // bit-in-word index, and the same with room for WORD_BITS itself
    localparam int BW        = $clog2(WORD_BITS);
    localparam int EW        = BW + 1;

    typedef logic [WORD_BITS-1:0] t_word;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ALIGN,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_RUN_RD,
        S_RUN_CHK,
        S_RMW_RD,
        S_RMW_WR,
        S_DONE
    } t_state;

    // mask of the bits below position b
    function automatic t_word low_mask(input logic [BW-1:0] b);
        return ~({WORD_BITS{1'b1}} << b);
    endfunction

    // lowest clear bit; the caller makes sure there is one
    function automatic logic [BW-1:0] first_zero(input t_word v);
        logic [BW-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!v[i]) begin
                idx = BW'(i);
            end
        end
        return idx;
    endfunction

    // lowest set bit, WORD_BITS when none
    function automatic logic [EW-1:0] first_one(input t_word v);
        logic [EW-1:0] idx;
        idx = EW'(WORD_BITS);
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = EW'(i);
            end
        end
        return idx;
    endfunction

    // ---------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------
    t_state            r_state,      n_state;
    logic [CNT_W-1:0]  r_pool,       n_pool;       // pool_pages register
    logic [PAGE_W-1:0] r_base,       n_base;       // base_page_offset register
    logic [CNT_W-1:0]  r_pu,         n_pu;         // pages in use
    logic [OP_W-1:0]   r_op,         n_op;
    logic [CNT_W-1:0]  r_num,        n_num;
    logic [PAGE_W-1:0] r_first_pg,   n_first_pg;
    logic [CNT_W-1:0]  r_mask,       n_mask;       // alignment mask
    logic [NW-1:0]     r_astart,     n_astart;     // first aligned pool page
    logic [NW-1:0]     r_nwords,     n_nwords;     // searchable whole words
    logic [NW-1:0]     r_abs,        n_abs;        // current candidate page
    logic [NW-1:0]     r_w,          n_w;          // current word
    logic [BW-1:0]     r_b,          n_b;          // current bit in word
    logic [NW-1:0]     r_sw,         n_sw;         // run start word
    logic [BW-1:0]     r_sb,         n_sb;         // run start bit
    logic [CNT_W-1:0]  r_rem,        n_rem;        // pages still to check or mark
    logic              r_first_wd,   n_first_wd;   // scan: ignore bits below r_b
    logic              r_brk,        n_brk;        // scan follows a broken run
    logic              r_set,        n_set;        // mark used, else clear
    logic              r_ok,         n_ok;
    logic              r_out_valid,  n_out_valid;
    t_rsp              r_out,        n_out;
    logic [NUM_WORDS-1:0] r_row_valid;             // ram word written since reset
    logic              r_rd_valid;

    // ---------------------------------------------------------------
    // datapath
    // ---------------------------------------------------------------
    logic              ram_we;
    t_word             ram_wdata;
    t_word             ram_q;
    t_word             w_word;
    logic [AW-1:0]     w_addr;

    logic [NW-1:0]     w_total;
    logic [CNT_W-1:0]  w_req_mask;
    logic [CNT_W:0]    w_req_sum;
    logic [NW-1:0]     w_req_astart;
    logic [NW-1:0]     w_free_w;
    logic [CNT_W-1:0]  w_off;
    logic [NW-1:0]     w_adj;

    t_word             w_pre;
    t_word             w_bits;
    logic [BW-1:0]     w_fz;
    logic [NW-1:0]     w_fz_abs;

    t_word             w_used;
    logic [EW-1:0]     w_f;
    logic [EW-1:0]     w_avail;

    logic [EW-1:0]     w_room;
    logic [EW-1:0]     w_k;
    logic [EW-1:0]     w_e;
    t_word             w_rmw_mask;
    logic              w_rmw_last;

    logic [CNT_W:0]    w_pu_sum;

    assign w_addr = r_w[AW-1:0];

    bpa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS),
        .AW    (AW)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (w_addr),
        .i_wdata (ram_wdata),
        .i_raddr (w_addr),
        .o_rdata (ram_q)
    );

    // a word never written since reset is all free
    assign w_word = r_rd_valid ? ram_q : '0;

    // pool size, clipped to the bitmap
    assign w_total = (NW'(r_pool) > NW'(MAX_POOL_PAGES)) ? NW'(MAX_POOL_PAGES)
                                                         : NW'(r_pool);

    // alignment of a new request: first pool page on an aligned absolute page
    assign w_req_mask   = (i_req.data.opcode == OP_ALLOC_ALIGNED)
                        ? i_req.data.page_count - CNT_W'(1) : '0;
    assign w_req_sum    = ((CNT_W + 1)'(r_base) + (CNT_W + 1)'(w_req_mask))
                        & ~(CNT_W + 1)'(w_req_mask);
    assign w_req_astart = NW'(w_req_sum) - NW'(r_base);

    // word holding the first page of a free
    assign w_free_w = NW'(i_req.data.first_page) >> BW;

    // misalignment of the candidate and the step past it
    assign w_off = CNT_W'(r_abs - r_astart) & r_mask;
    assign w_adj = r_abs + NW'(r_num) - NW'(w_off);

    // free-page scan of one word
    assign w_pre    = r_first_wd ? low_mask(r_b) : '0;
    assign w_bits   = w_word | w_pre;
    assign w_fz     = first_zero(w_bits);
    assign w_fz_abs = (r_w << BW) + NW'(w_fz);

    // free run length from r_b within one word
    assign w_used  = w_word & ~low_mask(r_b);
    assign w_f     = first_one(w_used);
    assign w_avail = w_f - EW'(r_b);

    // bits of one word to mark or clear
    assign w_room     = EW'(WORD_BITS) - EW'(r_b);
    assign w_k        = (r_rem <= CNT_W'(w_room)) ? EW'(r_rem) : w_room;
    assign w_e        = EW'(r_b) + w_k;
    assign w_rmw_mask = ({WORD_BITS{1'b1}} << r_b) & ~({WORD_BITS{1'b1}} << w_e);
    assign w_rmw_last = (r_rem <= CNT_W'(w_room))
                     || ((r_w + NW'(1)) >= NW'(NUM_WORDS));

    assign w_pu_sum = (CNT_W + 1)'(r_pu) + (CNT_W + 1)'(r_num);

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_pool      = r_pool;
        n_base      = r_base;
        n_pu        = r_pu;
        n_op        = r_op;
        n_num       = r_num;
        n_first_pg  = r_first_pg;
        n_mask      = r_mask;
        n_astart    = r_astart;
        n_nwords    = r_nwords;
        n_abs       = r_abs;
        n_w         = r_w;
        n_b         = r_b;
        n_sw        = r_sw;
        n_sb        = r_sb;
        n_rem       = r_rem;
        n_first_wd  = r_first_wd;
        n_brk       = r_brk;
        n_set       = r_set;
        n_ok        = r_ok;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_wdata   = r_set ? (w_word | w_rmw_mask) : (w_word & ~w_rmw_mask);

        // configuration writes
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_POOL_PAGES:  n_pool = i_cfg_data;
                CFG_BASE_OFFSET: n_base = i_cfg_data[PAGE_W-1:0];
                default: ;
            endcase
        end

        // result word taken
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op       = i_req.data.opcode;
                    n_num      = i_req.data.page_count;
                    n_first_pg = i_req.data.first_page;
                    n_mask     = w_req_mask;
                    n_astart   = w_req_astart;
                    unique case (i_req.data.opcode) inside
                        OP_ALLOC, OP_ALLOC_ALIGNED: begin
                            if (i_req.data.page_count == '0) begin
                                n_ok    = 1'b0;
                                n_state = S_DONE;
                            end else begin
                                n_nwords   = w_total >> BW;
                                n_abs      = w_req_astart;
                                n_w        = w_req_astart >> BW;
                                n_b        = w_req_astart[BW-1:0];
                                n_first_wd = 1'b1;
                                n_brk      = 1'b0;
                                n_state    = S_SCAN_RD;
                            end
                        end
                        OP_FREE: begin
                            n_w  = w_free_w;
                            n_b  = i_req.data.first_page[BW-1:0];
                            n_ok = 1'b1;
                            // run starts past the bitmap, or is empty
                            if (w_free_w >= NW'(NUM_WORDS)
                                    || i_req.data.page_count == '0) begin
                                n_state = S_DONE;
                            end else begin
                                n_set   = 1'b0;
                                n_rem   = i_req.data.page_count;
                                n_state = S_RMW_RD;
                            end
                        end
                        default: begin
                            n_ok    = 1'b0;
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_ALIGN: begin
                if (w_off != '0) begin
                    // step to the next aligned candidate and search from there
                    n_abs      = w_adj;
                    n_w        = w_adj >> BW;
                    n_b        = w_adj[BW-1:0];
                    n_first_wd = 1'b1;
                    n_brk      = 1'b0;
                    n_state    = S_SCAN_RD;
                end else if (r_brk) begin
                    n_first_wd = 1'b1;
                    n_brk      = 1'b0;
                    n_state    = S_SCAN_RD;
                end else begin
                    n_sw    = r_w;
                    n_sb    = r_b;
                    n_rem   = r_num;
                    n_state = S_RUN_RD;
                end
            end

            S_SCAN_RD: begin
                if (r_w >= r_nwords) begin
                    n_ok    = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_state = S_SCAN_CHK;
                end
            end

            S_SCAN_CHK: begin
                if (&w_bits) begin
                    n_w        = r_w + NW'(1);
                    n_first_wd = 1'b0;
                    n_state    = S_SCAN_RD;
                end else begin
                    n_b     = w_fz;
                    n_abs   = w_fz_abs;
                    n_state = S_ALIGN;
                end
            end

            S_RUN_RD: begin
                if (r_w >= r_nwords) begin
                    n_ok    = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_state = S_RUN_CHK;
                end
            end

            S_RUN_CHK: begin
                if (r_rem <= CNT_W'(w_avail)) begin
                    // whole run free: go mark it
                    n_w     = r_sw;
                    n_b     = r_sb;
                    n_rem   = r_num;
                    n_set   = 1'b1;
                    n_state = S_RMW_RD;
                end else if (w_f != EW'(WORD_BITS)) begin
                    // used page inside the run: search on from it
                    n_b        = w_f[BW-1:0];
                    n_first_wd = 1'b1;
                    n_brk      = 1'b1;
                    n_state    = S_SCAN_RD;
                end else begin
                    n_rem   = r_rem - CNT_W'(w_avail);
                    n_w     = r_w + NW'(1);
                    n_b     = '0;
                    n_state = S_RUN_RD;
                end
            end

            S_RMW_RD: begin
                n_state = S_RMW_WR;
            end

            S_RMW_WR: begin
                ram_we = 1'b1;
                if (w_rmw_last) begin
                    n_ok    = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_rem   = r_rem - CNT_W'(w_k);
                    n_w     = r_w + NW'(1);
                    n_b     = '0;
                    n_state = S_RMW_RD;
                end
            end

            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid        = 1'b1;
                    n_out.success      = r_ok;
                    n_out.start_page   = '0;
                    n_out.pages_in_use = r_pu;
                    if (r_op == OP_FREE) begin
                        n_out.start_page = r_first_pg;
                        n_pu = (r_pu > r_num) ? r_pu - r_num : '0;
                    end else if (r_ok) begin
                        n_out.start_page = r_abs[PAGE_W-1:0];
                        n_pu = w_pu_sum[CNT_W] ? COUNT_MAX : w_pu_sum[CNT_W-1:0];
                    end
                    n_out.pages_in_use = n_pu;
                    n_state            = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pool      <= POOL_PAGES_RST;
            r_base      <= BASE_OFFS_RST;
            r_pu        <= '0;
            r_out_valid <= 1'b0;
            r_row_valid <= '0;
            r_rd_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pool      <= n_pool;
            r_base      <= n_base;
            r_pu        <= n_pu;
            r_out_valid <= n_out_valid;
            r_rd_valid  <= (r_w < NW'(NUM_WORDS)) && r_row_valid[w_addr];
            if (ram_we) begin
                r_row_valid[w_addr] <= 1'b1;
            end
        end
        r_op       <= n_op;
        r_num      <= n_num;
        r_first_pg <= n_first_pg;
        r_mask     <= n_mask;
        r_astart   <= n_astart;
        r_nwords   <= n_nwords;
        r_abs      <= n_abs;
        r_w        <= n_w;
        r_b        <= n_b;
        r_sw       <= n_sw;
        r_sb       <= n_sb;
        r_rem      <= n_rem;
        r_first_wd <= n_first_wd;
        r_brk      <= n_brk;
        r_set      <= n_set;
        r_ok       <= n_ok;
        r_out      <= n_out;
    end

    // handshake
    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// self-checking testbench of the bitmap page allocator
`default_nettype none

module testbench;
    import bpa_pkg::*;

    localparam int NPAGES = 4096;
    localparam int WBITS  = 64;
    localparam int RANDOM_WORDS = 1300;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0] i_cfg_data;

    bpa_stream_if #(.T(t_req)) req_if ();
    bpa_stream_if #(.T(t_rsp)) rsp_if ();

    bitmap_page_allocator_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req       (req_if.sink),
        .o_rsp       (rsp_if.source)
    );

    // predictor state: used-page bitmap, count and both registers
    logic [NPAGES-1:0] used_map;
    int unsigned       used_count;
    int unsigned       pool_reg;
    int unsigned       offs_reg;

    t_req pending_words[$];   // requests waiting for the driver
    t_rsp expected_rsps[$];   // predicted results, oldest first
    int   error_count;
    bit   stim_done;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit: far above the slowest run of the whole stimulus
    initial begin
        #400000000;
        $display("Simulation FAILED");
        $finish;
    end

    // lowest free page at or after from, whole words below the pool only
    function automatic longint find_free(longint from);
        longint total;
        longint p;
        total = (pool_reg > NPAGES) ? NPAGES : pool_reg;
        if (from >= total) return -1;
        for (p = from; p < (total / WBITS) * WBITS; p++)
            if (!used_map[p]) return p;
        return -1;
    endfunction

    function automatic longint find_run(longint num, longint mask);
        longint astart, nxt, start, last, got;
        astart = ((longint'(offs_reg) + mask) & ~mask) - offs_reg;
        nxt = astart;
        forever begin
            if (((nxt - astart) & mask) != 0)
                nxt += num - ((nxt - astart) & mask);
            nxt = find_free(nxt);
            start = nxt;
            if (start < 0 || num == 0) return -1;
            if (((start - astart) & mask) != 0) continue;
            got = 1;
            last = start;
            while (got < num) begin
                nxt = find_free(last + 1);
                if (nxt < 0) return -1;
                if (nxt != last + 1) break;
                got++;
                last = nxt;
            end
            if (got < num) continue;
            for (longint i = 0; i < num; i++) used_map[start + i] = 1'b1;
            return start;
        end
    endfunction

    function automatic t_rsp predict_alloc(t_req rq);
        t_rsp   r;
        longint s;
        longint num;
        r = '0;
        num = rq.page_count;
        if (rq.opcode == OP_ALLOC || rq.opcode == OP_ALLOC_ALIGNED) begin
            s = find_run(num, (rq.opcode == OP_ALLOC_ALIGNED) ? ((num - 1) & 'h1fff) : 0);
            if (s >= 0) begin
                r.success = 1'b1;
                r.start_page = PAGE_W'(s);
                used_count = (used_count + num > 8191) ? 8191 : used_count + num;
            end
        end else if (rq.opcode == OP_FREE) begin
            r.success = 1'b1;
            r.start_page = rq.first_page;
            for (longint i = 0; i < num; i++) begin
                if (rq.first_page + i < NPAGES) used_map[rq.first_page + i] = 1'b0;
                if (used_count > 0) used_count--;
            end
        end
        r.pages_in_use = CNT_W'(used_count);
        return r;
    endfunction

    task automatic queue_word(logic [1:0] op, int cnt, int first);
        t_req rq;
        rq.opcode = op;
        rq.page_count = CNT_W'(cnt);
        rq.first_page = PAGE_W'(first);
        pending_words.push_back(rq);
        expected_rsps.push_back(predict_alloc(rq));
    endtask

    // wait until every result is back, then let the block settle
    task automatic drain();
        while (pending_words.size() != 0 || expected_rsps.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, int value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_W'(value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_POOL_PAGES) pool_reg = value;
        else offs_reg = value;
    endtask

    // one random request; mostly small runs so searches stay short
    task automatic random_word();
        int sel, cnt, op;
        sel = $urandom_range(0, 99);
        if (sel < 3) cnt = $urandom_range(0, 8191);
        else if (sel < 10) cnt = $urandom_range(64, 600);
        else cnt = $urandom_range(0, 40);
        op = $urandom_range(0, 99);
        if (op < 38) queue_word(OP_ALLOC, cnt, 0);
        else if (op < 70) queue_word(OP_ALLOC_ALIGNED,
                ($urandom_range(0, 9) == 0) ? cnt : (1 << $urandom_range(0, 7)), 0);
        else if (op < 98) queue_word(OP_FREE, cnt, $urandom_range(0, 4095));
        else queue_word(2'd3, cnt, $urandom_range(0, 4095));
    endtask

    // stimulus: directed corners, then random phases under several settings
    initial begin
        int pools[6];
        int offs[6];
        used_map = '0;
        used_count = 0;
        pool_reg = 4096;
        offs_reg = 0;
        error_count = 0;
        stim_done = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_POOL_PAGES;
        i_cfg_data = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero count, single page, aligned, whole pool, free, unused opcode
        queue_word(OP_ALLOC, 0, 0);
        queue_word(OP_ALLOC_ALIGNED, 0, 4095);
        queue_word(OP_ALLOC, 1, 0);
        queue_word(OP_ALLOC_ALIGNED, 8, 0);
        queue_word(OP_ALLOC_ALIGNED, 3, 0);
        queue_word(OP_ALLOC, 4096, 0);
        queue_word(OP_ALLOC, 8191, 0);
        queue_word(OP_FREE, 0, 4095);
        queue_word(OP_FREE, 8191, 4095);
        queue_word(2'd3, 8191, 4095);
        queue_word(OP_ALLOC, 4096, 0);
        queue_word(OP_ALLOC, 4096, 0);
        queue_word(OP_FREE, 8191, 0);
        queue_word(OP_FREE, 10, 4090);
        queue_word(OP_ALLOC_ALIGNED, 4096, 0);
        queue_word(OP_FREE, 4096, 0);
        drain();

        // partial trailing word, a free back to zero and alignment under a base offset
        write_reg(CFG_POOL_PAGES, 100);
        write_reg(CFG_BASE_OFFSET, 4095);
        queue_word(OP_ALLOC, 64, 0);
        queue_word(OP_ALLOC, 1, 0);
        queue_word(OP_ALLOC_ALIGNED, 1, 0);
        queue_word(OP_FREE, 64, 0);
        queue_word(OP_ALLOC_ALIGNED, 16, 0);
        drain();

        pools = '{8191, 0, 63, 200, 1000, 4096};
        offs  = '{4095, 0, 1, 37, 4095, 0};
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_POOL_PAGES, (ph == 5) ? 4096 : pools[ph]);
            write_reg(CFG_BASE_OFFSET, (ph == 5) ? $urandom_range(0, 4095) : offs[ph]);
            for (int n = 0; n < RANDOM_WORDS / 6; n++) random_word();
            drain();
        end
        stim_done = 1'b1;
    end

    // driver: bursts of random length with random gaps
    int burst_left;
    int gap_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            req_if.data  <= '0;
            burst_left   <= 0;
            gap_left     <= 0;
        end else begin
            // a word goes when valid and ready meet
            if (req_if.valid && req_if.ready) void'(pending_words.pop_front());
            if (req_if.valid && !req_if.ready) begin
                // hold the offered word
            end else if (gap_left > 0) begin
                req_if.valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else begin
                if (pending_words.size() != 0) begin
                    req_if.valid <= 1'b1;
                    req_if.data  <= pending_words[0];
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 30);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: receiver stalls on a pattern, results checked in order
    int stall_phase;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            stall_phase  <= 0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (expected_rsps.size() == 0) begin
                    $error("result word with nothing expected");
                    error_count++;
                end else begin
                    automatic t_rsp exp_w = expected_rsps.pop_front();
                    if (rsp_if.data.success !== exp_w.success) begin
                        $error("success exp %0d got %0d", exp_w.success, rsp_if.data.success);
                        error_count++;
                    end
                    if (rsp_if.data.start_page !== exp_w.start_page) begin
                        $error("start_page exp %0d got %0d",
                               exp_w.start_page, rsp_if.data.start_page);
                        error_count++;
                    end
                    if (rsp_if.data.pages_in_use !== exp_w.pages_in_use) begin
                        $error("pages_in_use exp %0d got %0d",
                               exp_w.pages_in_use, rsp_if.data.pages_in_use);
                        error_count++;
                    end
                end
            end
            stall_phase <= (stall_phase + 1) % 97;
            // no stalls in the first stretch, then an uneven pattern
            rsp_if.ready <= (stall_phase < 30) ? 1'b1 :
                            (((stall_phase * 7) % 11) > 3) || ($urandom_range(0, 3) == 0);
        end
    end

    // end of run
    initial begin
        @(posedge stim_done);
        repeat (40) @(posedge i_clk);
        if (expected_rsps.size() != 0) begin
            $error("results still expected at end: %0d", expected_rsps.size());
            error_count++;
        end
        if (error_count == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end
endmodule

`default_nettype wire

// ===== files.f =====
sv/bpa_pkg.sv
sv/bpa_stream_if.sv
sv/bpa_ram.sv
sv/bitmap_page_allocator_top.sv
tb/sv/testbench.sv
